@@ src/pi_differential_steering_top_assert.svh @@
// assertion macros for the differential steering controller
`ifndef PI_DIFFERENTIAL_STEERING_TOP_ASSERT_SVH
`define PI_DIFFERENTIAL_STEERING_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define PIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pids assertion failed");

// next-cycle implication, disabled in reset
`define PIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pids assertion failed");

`else

`define PIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/pids_pkg.sv @@
// shared widths, register codes and config type for the steering controller
`timescale 1ns / 1ps

package pids_pkg;

    // field widths
    localparam int ERR_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int PGAIN_W    = 12;
    localparam int IGAIN_W    = 5;
    localparam int LIMIT_W    = 15;
    localparam int INTEG_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_ERROR_BOOST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN_Q4     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_Q4    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET      = 3'd7;

    // reset values
    localparam logic [DUTY_W-1:0]  RST_BASE_DUTY        = 8'd120;
    localparam logic [DUTY_W-1:0]  RST_ZERO_ERROR_BOOST = 8'd120;
    localparam logic [PGAIN_W-1:0] RST_PROP_GAIN_Q4     = 12'd160;
    localparam logic [IGAIN_W-1:0] RST_INTEG_GAIN_Q4    = 5'd8;
    localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT   = 15'd100;
    localparam logic [DUTY_W-1:0]  RST_DUTY_MIN         = 8'd70;
    localparam logic [DUTY_W-1:0]  RST_DUTY_MAX         = 8'd255;
    localparam logic [DUTY_W-1:0]  RST_LEFT_OFFSET      = 8'd5;

    // unity integral gain in q4
    localparam logic [IGAIN_W-1:0] IGAIN_UNITY = 5'd16;

    typedef struct packed {
        logic [DUTY_W-1:0]  base_duty;
        logic [DUTY_W-1:0]  zero_error_boost;
        logic [PGAIN_W-1:0] prop_gain_q4;
        logic [IGAIN_W-1:0] integ_gain_q4;
        logic [LIMIT_W-1:0] integral_limit;
        logic [DUTY_W-1:0]  duty_min;
        logic [DUTY_W-1:0]  duty_max;
        logic [DUTY_W-1:0]  left_offset;
    } cfg_t;

endpackage

@@ src/pids_err_if.sv @@
// steering error request channel
`timescale 1ns / 1ps

interface pids_err_if;
    logic                                valid;
    logic                                ready;
    logic signed [pids_pkg::ERR_W-1:0]   steer_error;

    modport source (output valid, output steer_error, input ready);
    modport sink (input valid, input steer_error, output ready);
endinterface

@@ src/pids_duty_if.sv @@
// duty result request channel
`timescale 1ns / 1ps

interface pids_duty_if;
    logic                          valid;
    logic                          ready;
    logic [pids_pkg::DUTY_W-1:0]   left_duty;
    logic [pids_pkg::DUTY_W-1:0]   right_duty;

    modport source (output valid, output left_duty, output right_duty, input ready);
    modport sink (input valid, input left_duty, input right_duty, output ready);
endinterface

@@ src/pids_cfg_if.sv @@
// configuration write request channel
`timescale 1ns / 1ps

interface pids_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pids_pkg::CFG_IDX_W-1:0]    index;
    logic [pids_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/pids_cfg_regs.sv @@
// configuration register file of the steering controller
`timescale 1ns / 1ps

module pids_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    pids_cfg_if.sink         cfg,
    output pids_pkg::cfg_t   regs
);
    import pids_pkg::*;

    cfg_t regs_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register writes, each field keeps its low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.base_duty        <= RST_BASE_DUTY;
            regs_reg.zero_error_boost <= RST_ZERO_ERROR_BOOST;
            regs_reg.prop_gain_q4     <= RST_PROP_GAIN_Q4;
            regs_reg.integ_gain_q4    <= RST_INTEG_GAIN_Q4;
            regs_reg.integral_limit   <= RST_INTEGRAL_LIMIT;
            regs_reg.duty_min         <= RST_DUTY_MIN;
            regs_reg.duty_max         <= RST_DUTY_MAX;
            regs_reg.left_offset      <= RST_LEFT_OFFSET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BASE_DUTY:        regs_reg.base_duty        <= cfg.data[DUTY_W-1:0];
                REG_ZERO_ERROR_BOOST: regs_reg.zero_error_boost <= cfg.data[DUTY_W-1:0];
                REG_PROP_GAIN_Q4:     regs_reg.prop_gain_q4     <= cfg.data[PGAIN_W-1:0];
                REG_INTEG_GAIN_Q4:    regs_reg.integ_gain_q4    <= cfg.data[IGAIN_W-1:0];
                REG_INTEGRAL_LIMIT:   regs_reg.integral_limit   <= cfg.data[LIMIT_W-1:0];
                REG_DUTY_MIN:         regs_reg.duty_min         <= cfg.data[DUTY_W-1:0];
                REG_DUTY_MAX:         regs_reg.duty_max         <= cfg.data[DUTY_W-1:0];
                REG_LEFT_OFFSET:      regs_reg.left_offset      <= cfg.data[DUTY_W-1:0];
                default:              ;
            endcase
        end
    end

endmodule

@@ src/pi_differential_steering_top.sv @@
// top level of the pi differential steering controller
//
// channel   role   payload
// steer     sink   steer_error (16 bit signed)
// duty      source left_duty, right_duty (8 bit each)
// cfg       sink   index (3 bit), data (15 bit); always ready
//
// one error request per cycle while the duty channel takes results; after the accept edge
// a request passes the input register, then the integral/product stage, then the duty output register
// the integral register closes a single-register loop: add, clamp, scale by gain
// a stalled result stalls the stages behind it only as far as they are full
// reset clears the integral to zero and loads the register defaults
`timescale 1ns / 1ps
`include "pi_differential_steering_top_assert.svh"

module pi_differential_steering_top (
    input  logic          clk,
    input  logic          rst_n,
    pids_err_if.sink      steer,
    pids_duty_if.source   duty,
    pids_cfg_if.sink      cfg
);
    import pids_pkg::*;

    cfg_t cfg_q;

    // stage handshake
    logic en_out;
    logic en_s2;
    logic en_s1;

    // input stage
    logic                     s1_valid_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;

    // integral stage
    logic signed [INTEG_W-1:0] acc_reg;
    logic signed [INTEG_W-1:0] acc_next;
    logic signed [16:0]        sum_wide;
    logic signed [16:0]        lim_pos;
    logic signed [16:0]        lim_neg;
    logic signed [16:0]        sum_clamp;
    logic signed [15:0]        sum_c16;
    logic [IGAIN_W-1:0]        gain_eff;
    logic signed [21:0]        scaled;
    logic signed [21:0]        biased;
    logic signed [28:0]        prod;
    logic [8:0]                base_sum;

    logic                      s2_valid_reg;
    logic signed [28:0]        s2_prod_reg;
    logic signed [INTEG_W-1:0] s2_integ_reg;
    logic [8:0]                s2_base_reg;

    // duty stage
    logic signed [19:0] integ_q4;
    logic signed [29:0] total_q4;
    logic signed [30:0] base_q4;
    logic signed [30:0] left_q4;
    logic signed [30:0] right_q4;
    logic signed [26:0] left_fl;
    logic signed [26:0] right_fl;
    logic signed [27:0] left_int;
    logic signed [27:0] right_int;
    logic [DUTY_W-1:0]  left_clamp;
    logic [DUTY_W-1:0]  right_clamp;

    logic               out_valid_reg;
    logic [DUTY_W-1:0]  left_reg;
    logic [DUTY_W-1:0]  right_reg;

    // when the bounds cross, values below the lower bound give the lower bound, all others the upper bound
    function automatic logic [DUTY_W-1:0] clamp_duty(
        input logic signed [27:0] v,
        input logic [DUTY_W-1:0]  lo,
        input logic [DUTY_W-1:0]  hi
    );
        logic signed [27:0] lo_s;
        logic signed [27:0] hi_s;
        logic [DUTY_W-1:0]  res;
        lo_s = {20'd0, lo};
        hi_s = {20'd0, hi};
        priority if (v < lo_s)
            res = lo;
        else if (v > hi_s)
            res = hi;
        else
            res = v[DUTY_W-1:0];
        return res;
    endfunction

    pids_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    // stage enables
    assign en_out      = !out_valid_reg || duty.ready;
    assign en_s2       = !s2_valid_reg || en_out;
    assign en_s1       = !s1_valid_reg || en_s2;
    assign steer.ready = en_s1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en_s1)
            s1_valid_reg <= steer.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && steer.valid)
            s1_err_reg <= steer.steer_error;
    end

    // integral update: add, clamp, scale, truncate toward zero
    always_comb
    begin
        sum_wide = {acc_reg[15], acc_reg} + {s1_err_reg[15], s1_err_reg};
        lim_pos  = {2'b00, cfg_q.integral_limit};
        lim_neg  = -lim_pos;
        priority if (sum_wide > lim_pos)
            sum_clamp = lim_pos;
        else if (sum_wide < lim_neg)
            sum_clamp = lim_neg;
        else
            sum_clamp = sum_wide;
        sum_c16  = sum_clamp[15:0];
        gain_eff = (cfg_q.integ_gain_q4 > IGAIN_UNITY) ? IGAIN_UNITY : cfg_q.integ_gain_q4;
        scaled   = sum_c16 * $signed({1'b0, gain_eff});
        biased   = scaled + (scaled[21] ? 22'sd15 : 22'sd0);
        acc_next = biased[19:4];
    end

    // proportional product and base duty
    always_comb
    begin
        prod     = $signed({1'b0, cfg_q.prop_gain_q4}) * s1_err_reg;
        base_sum = {1'b0, cfg_q.base_duty}
                 + ((s1_err_reg == '0) ? {1'b0, cfg_q.zero_error_boost} : 9'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else if (en_s2)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s2 && s1_valid_reg)
        begin
            s2_prod_reg  <= prod;
            s2_integ_reg <= acc_next;
            s2_base_reg  <= base_sum;
        end
    end

    // q4 total, floor, left trim and clamp
    always_comb
    begin
        integ_q4    = {s2_integ_reg, 4'b0000};
        total_q4    = {s2_prod_reg[28], s2_prod_reg} + {{10{integ_q4[19]}}, integ_q4};
        base_q4     = {18'd0, s2_base_reg, 4'b0000};
        left_q4     = base_q4 - {total_q4[29], total_q4};
        right_q4    = base_q4 + {total_q4[29], total_q4};
        left_fl     = left_q4[30:4];
        right_fl    = right_q4[30:4];
        left_int    = {left_fl[26], left_fl}
                    + {{20{cfg_q.left_offset[7]}}, cfg_q.left_offset};
        right_int   = {right_fl[26], right_fl};
        left_clamp  = clamp_duty(left_int, cfg_q.duty_min, cfg_q.duty_max);
        right_clamp = clamp_duty(right_int, cfg_q.duty_min, cfg_q.duty_max);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg)
        begin
            left_reg  <= left_clamp;
            right_reg <= right_clamp;
        end
    end

    assign duty.valid      = out_valid_reg;
    assign duty.left_duty  = left_reg;
    assign duty.right_duty = right_reg;

    // checks
    `PIDS_ASSERT_IMPL(a_integ_range, clk, rst_n, 1'b1, acc_reg != 16'sh8000)
    `PIDS_ASSERT_NEXT(a_integ_hold, clk, rst_n, !(en_s2 && s1_valid_reg), $stable(acc_reg))
    `PIDS_ASSERT_IMPL(a_out_source, clk, rst_n, $rose(out_valid_reg), $past(s2_valid_reg))

endmodule
